// File: hdl/analog_stick_pointer_and_direction_unit_macros.svh
// Assertion macros for the analog stick pointer and direction unit.
// Used by the top level only; expects clock and reset in scope.
`ifndef ANALOG_STICK_POINTER_AND_DIRECTION_UNIT_MACROS_SVH
`define ANALOG_STICK_POINTER_AND_DIRECTION_UNIT_MACROS_SVH

// same-cycle implication
`define ASPD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/aspd_pkg.sv
// Shared types, constants and codes of the analog stick pointer and direction unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package aspd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int AXIS_MAX   = 32767;
   localparam int MAG_W      = 16 + FRAC_BITS;
   localparam int WIDE_W     = 48;
   localparam int ACC_W      = 52;
   localparam int DREM_W     = 33;
   localparam int SREM_W     = 35;
   localparam int OPB_W      = 32;
   localparam int MUL_STEPS  = 20;
   localparam int DIV_STEPS  = WIDE_W;
   localparam int SQRT_STEPS = MAG_W;

   localparam logic [31:0] MAG_CAP =
      32'(((64'(AXIS_MAX) * 64'd5) << FRAC_BITS) >> 2);
   localparam logic [15:0] SLOPE =
      16'((64'd1779033704 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam logic [15:0] AXIS_LIMIT = 16'(AXIS_MAX);

   localparam logic [15:0] DIV_BASE      = 16'd4096;
   localparam logic [15:0] DIV_FAST      = 16'(4096 / 3);
   localparam logic [15:0] DIV_SLOW      = 16'(4096 * 8);
   localparam logic [15:0] DIV_FAST_SLOW = 16'((4096 / 3) * 8);

   localparam logic [14:0] RST_STICK_DZ = 15'd2000;
   localparam logic [15:0] RST_DIR_DZ   = 16'd10240;
   localparam logic [23:0] RST_TPF      = 24'(19200 * 25);
   localparam logic [11:0] RST_WIDTH    = 12'd1280;
   localparam logic [11:0] RST_HEIGHT   = 12'd720;

   localparam logic [2:0] REG_STICK_DZ = 3'd0;
   localparam logic [2:0] REG_DIR_DZ   = 3'd1;
   localparam logic [2:0] REG_TPF      = 3'd2;
   localparam logic [2:0] REG_WIDTH    = 3'd3;
   localparam logic [2:0] REG_HEIGHT   = 3'd4;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_SPEED  = 1'b1;
   localparam logic EVENT_MOTION = 1'b0;
   localparam logic EVENT_KEY    = 1'b1;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_SQ_LX, ST_SQ_LY, ST_SQRT, ST_MX, ST_RATIO, ST_KMUL,
      ST_OXM, ST_OXD, ST_OYM, ST_OYD, ST_FIX, ST_TIME, ST_FACT, ST_TSX, ST_TSY,
      ST_DIVX, ST_DIVY, ST_SQ_RX, ST_SQ_RY, ST_SQ_DZ, ST_SLX, ST_SLY, ST_EMIT
   } eng_state_type;

   typedef struct packed {
      logic [14:0] stick_dz;
      logic [15:0] dir_dz;
      logic [23:0] tpf;
      logic [11:0] width;
      logic [11:0] height;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] left_x;
      logic [15:0] left_y;
      logic [15:0] right_x;
      logic [15:0] right_y;
      logic [31:0] elapsed_ticks;
      logic [11:0] pointer_x;
      logic [11:0] pointer_y;
      logic        fast_request;
      logic        slow_request;
   } req_type;

   typedef struct packed {
      logic        event_kind;
      logic [11:0] new_x;
      logic [11:0] new_y;
      logic [12:0] move_x;
      logic [12:0] move_y;
      logic [1:0]  direction;
      logic        pressed;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/aspd_serial_alu.sv
// Bit-serial arithmetic unit: shift-add multiply, restoring divide, square root.
// One bit (or one radicand digit pair) per cycle; uses aspd_pkg.
`default_nettype none

module aspd_serial_alu import aspd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire alu_op_type        op,
   input  wire logic [WIDE_W-1:0] opa,
   input  wire logic [OPB_W-1:0]  opb,
   output logic                   done,
   output logic [ACC_W-1:0]       result,
   output logic [DREM_W-1:0]      remainder
);

   alu_op_type         op_ff, op_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [ACC_W-1:0]   sh_ff, sh_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SREM_W-1:0]  rem_ff, rem_in;
   logic [OPB_W-1:0]   mp_ff, mp_in;

   logic [DREM_W-1:0]  trial_div;
   logic               fits_div;
   logic [SREM_W-1:0]  r4;
   logic [SREM_W-1:0]  trial_sq;
   logic               fits_sq;

   always_comb begin
      trial_div = {rem_ff[DREM_W-2:0], sh_ff[WIDE_W-1]};
      fits_div  = trial_div >= {1'b0, mp_ff};
      r4        = {rem_ff[SREM_W-3:0], sh_ff[ACC_W-1 -: 2]};
      trial_sq  = {1'b0, acc_ff[MAG_W-1:0], 2'b01};
      fits_sq   = r4 >= trial_sq;

      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      mp_in   = mp_ff;

      if (start) begin
         op_in   = op;
         busy_in = 1'b1;
         acc_in  = '0;
         rem_in  = '0;
         mp_in   = opb;
         unique case (op)
            ALU_MUL: begin
               sh_in  = ACC_W'(opa);
               cnt_in = 6'(MUL_STEPS);
            end
            ALU_DIV: begin
               sh_in  = ACC_W'(opa);
               cnt_in = 6'(DIV_STEPS);
            end
            ALU_SQRT: begin
               sh_in  = ACC_W'(opa[MAG_W-1:0]) << (ACC_W - MAG_W);
               cnt_in = 6'(SQRT_STEPS);
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + sh_ff;
               end
               sh_in = sh_ff << 1;
               mp_in = mp_ff >> 1;
            end
            ALU_DIV: begin
               sh_in = {sh_ff[ACC_W-2:0], fits_div};
               if (fits_div) begin
                  rem_in = SREM_W'(trial_div - {1'b0, mp_ff});
               end else begin
                  rem_in = SREM_W'(trial_div);
               end
            end
            ALU_SQRT: begin
               sh_in = sh_ff << 2;
               if (fits_sq) begin
                  rem_in = r4 - trial_sq;
                  acc_in = {acc_ff[ACC_W-2:0], 1'b1};
               end else begin
                  rem_in = r4;
                  acc_in = {acc_ff[ACC_W-2:0], 1'b0};
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      done      = done_ff;
      remainder = rem_ff[DREM_W-1:0];
      if (op_ff == ALU_DIV) begin
         result = ACC_W'(sh_ff[WIDE_W-1:0]);
      end else begin
         result = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      mp_ff  <= mp_in;
   end

endmodule

`default_nettype wire

// File: hdl/aspd_engine.sv
// Sequencer and datapath registers: dead zone, time scaling, accumulators, direction keys.
// Drives aspd_serial_alu for every wide step; uses aspd_pkg.
`default_nettype none

module aspd_engine import aspd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    item_valid,
   output logic         item_ready,
   input  wire req_type item,
   output logic         res_valid,
   output rsp_type      res,
   input  wire logic    res_ready
);

   eng_state_type state_ff, state_in;
   logic          go_ff, go_in;
   logic [15:0]   lx_ff, lx_in, ly_ff, ly_in, rx_ff, rx_in, ry_ff, ry_in;
   logic [31:0]   el_ff, el_in;
   logic [11:0]   px_ff, px_in, py_ff, py_in;
   logic [31:0]   m2_ff, m2_in, mag_ff, mag_in, mx_ff, mx_in, k_ff, k_in;
   logic [16:0]   r_ff, r_in;
   logic [WIDE_W-1:0] p_ff, p_in;
   logic [15:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic [19:0]   f_ff, f_in;
   logic [18:0]   tx_ff, tx_in, ty_ff, ty_in;
   logic [9:0]    qx_ff, qx_in, qy_ff, qy_in;
   logic [23:0]   subx_ff, subx_in, suby_ff, suby_in;
   logic          fast_ff, fast_in, slow_ff, slow_in;
   logic [3:0]    held_ff, held_in, now_ff, now_in;
   logic [31:0]   h2_ff, h2_in, sp_ff, sp_in;
   logic [4:0]    pend_ff, pend_in;

   logic              alu_start, alu_done;
   alu_op_type        alu_op;
   logic [WIDE_W-1:0] alu_a;
   logic [OPB_W-1:0]  alu_b;
   logic [ACC_W-1:0]  alu_res;
   logic [DREM_W-1:0] alu_rem;

   logic [15:0] ax, ay, hx, hy, big;
   logic [31:0] dz_q, mxc;
   logic [35:0] el10;
   logic [27:0] tpf10;
   logic        unity;
   logic [15:0] divisor;
   logic [23:0] tx_s, ty_s, sx, sy, smx, smy;
   logic        motion, vert, horiz;
   logic [3:0]  now_c;
   logic [13:0] sumx, sumy;
   logic [11:0] nx, ny;
   logic [4:0]  pend_next;
   logic [1:0]  dir_sel;

   aspd_serial_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .start     (alu_start),
      .op        (alu_op),
      .opa       (alu_a),
      .opb       (alu_b),
      .done      (alu_done),
      .result    (alu_res),
      .remainder (alu_rem)
   );

   always_comb begin
      ax   = lx_ff[15] ? 16'(16'd0 - lx_ff) : lx_ff;
      ay   = ly_ff[15] ? 16'(16'd0 - ly_ff) : ly_ff;
      hx   = rx_ff[15] ? 16'(16'd0 - rx_ff) : rx_ff;
      hy   = ry_ff[15] ? 16'(16'd0 - ry_ff) : ry_ff;
      big  = (ax > ay) ? ax : ay;
      dz_q = 32'(cfg.stick_dz) << FRAC_BITS;

      el10  = 36'({el_ff, 3'b000}) + 36'({el_ff, 1'b0});
      tpf10 = 28'({cfg.tpf, 3'b000}) + 28'({cfg.tpf, 1'b0});
      unity = (cfg.tpf == 24'd0) || (el10 < 36'(cfg.tpf)) || (el_ff > 32'(tpf10));

      case ({fast_ff, slow_ff})
         2'b10:   divisor = DIV_FAST;
         2'b01:   divisor = DIV_SLOW;
         2'b11:   divisor = DIV_FAST_SLOW;
         default: divisor = DIV_BASE;
      endcase

      tx_s = lx_ff[15] ? 24'd0 - 24'(tx_ff) : 24'(tx_ff);
      ty_s = ly_ff[15] ? 24'd0 - 24'(ty_ff) : 24'(ty_ff);
      sx   = subx_ff + tx_s;
      sy   = suby_ff + ty_s;
      smx  = sx[23] ? 24'd0 - sx : sx;
      smy  = sy[23] ? 24'd0 - sy : sy;

      if (alu_res[31:0] > MAG_CAP) begin
         mxc = MAG_CAP;
      end else begin
         mxc = alu_res[31:0];
      end
      if (alu_res[WIDE_W-1:32] != '0) begin
         mxc = MAG_CAP;
      end
      if (mxc < mag_ff) begin
         mxc = mag_ff;
      end

      motion = (qx_ff != 10'd0) || (qy_ff != 10'd0);
      sumx   = 14'({2'b00, px_ff}) + {{4{qx_ff[9]}}, qx_ff};
      sumy   = 14'({2'b00, py_ff}) + {{4{qy_ff[9]}}, qy_ff};
      if (sumx[13]) begin
         nx = 12'd0;
      end else if (sumx > {2'b00, cfg.width}) begin
         nx = cfg.width;
      end else begin
         nx = sumx[11:0];
      end
      if (sumy[13]) begin
         ny = 12'd0;
      end else if (sumy > {2'b00, cfg.height}) begin
         ny = cfg.height;
      end else begin
         ny = sumy[11:0];
      end

      vert  = {hy, {FRAC_BITS{1'b0}}} > sp_ff;
      horiz = {hx, {FRAC_BITS{1'b0}}} > alu_res[31:0];
      now_c = 4'b0000;
      if (vert) begin
         now_c = now_c | (ry_ff[15] ? 4'b0001 : 4'b0010);
      end
      if (horiz) begin
         now_c = now_c | (rx_ff[15] ? 4'b0100 : 4'b1000);
      end

      pend_next = pend_ff;
      dir_sel   = 2'd0;
      if (pend_ff[0]) begin
         pend_next[0] = 1'b0;
      end else if (pend_ff[1]) begin
         pend_next[1] = 1'b0;
         dir_sel      = 2'd0;
      end else if (pend_ff[2]) begin
         pend_next[2] = 1'b0;
         dir_sel      = 2'd1;
      end else if (pend_ff[3]) begin
         pend_next[3] = 1'b0;
         dir_sel      = 2'd2;
      end else begin
         pend_next[4] = 1'b0;
         dir_sel      = 2'd3;
      end
   end

   always_comb begin
      state_in = state_ff;
      lx_in = lx_ff;  ly_in = ly_ff;  rx_in = rx_ff;  ry_in = ry_ff;
      el_in = el_ff;  px_in = px_ff;  py_in = py_ff;
      m2_in = m2_ff;  mag_in = mag_ff;  mx_in = mx_ff;  k_in = k_ff;
      r_in = r_ff;  p_in = p_ff;  ox_in = ox_ff;  oy_in = oy_ff;
      f_in = f_ff;  tx_in = tx_ff;  ty_in = ty_ff;  qx_in = qx_ff;  qy_in = qy_ff;
      subx_in = subx_ff;  suby_in = suby_ff;  fast_in = fast_ff;  slow_in = slow_ff;
      held_in = held_ff;  now_in = now_ff;  h2_in = h2_ff;  sp_in = sp_ff;
      pend_in = pend_ff;

      item_ready = state_ff == ST_IDLE;
      alu_start  = go_ff;
      alu_op     = ALU_MUL;
      alu_a      = '0;
      alu_b      = '0;
      res_valid  = 1'b0;
      res        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.kind == KIND_SPEED) begin
                  fast_in = item.fast_request;
                  slow_in = item.slow_request;
                  subx_in = '0;
                  suby_in = '0;
               end else begin
                  lx_in = item.left_x;
                  ly_in = item.left_y;
                  rx_in = item.right_x;
                  ry_in = item.right_y;
                  el_in = item.elapsed_ticks;
                  px_in = item.pointer_x;
                  py_in = item.pointer_y;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (cfg.stick_dz == 15'd0) begin
               ox_in = ax;
               oy_in = ay;
               state_in = ST_TIME;
            end else if (cfg.stick_dz >= 15'(AXIS_MAX)) begin
               ox_in = '0;
               oy_in = '0;
               state_in = ST_TIME;
            end else begin
               state_in = ST_SQ_LX;
            end
         end
         ST_SQ_LX: begin
            alu_a = WIDE_W'(ax);
            alu_b = OPB_W'(ax);
            if (alu_done) begin
               m2_in = alu_res[31:0];
               state_in = ST_SQ_LY;
            end
         end
         ST_SQ_LY: begin
            alu_a = WIDE_W'(ay);
            alu_b = OPB_W'(ay);
            if (alu_done) begin
               m2_in = m2_ff + alu_res[31:0];
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            alu_op = ALU_SQRT;
            alu_a  = WIDE_W'(m2_ff);
            if (alu_done) begin
               mag_in = alu_res[31:0];
               if (alu_res[31:0] <= dz_q) begin
                  ox_in = '0;
                  oy_in = '0;
                  state_in = ST_TIME;
               end else begin
                  state_in = ST_MX;
               end
            end
         end
         ST_MX: begin
            alu_op = ALU_DIV;
            alu_a  = (WIDE_W'(mag_ff) << 15) - WIDE_W'(mag_ff);
            alu_b  = OPB_W'(big);
            if (alu_done) begin
               mx_in = mxc;
               state_in = ST_RATIO;
            end
         end
         ST_RATIO: begin
            alu_op = ALU_DIV;
            alu_a  = WIDE_W'({mag_ff - dz_q, {FRAC_BITS{1'b0}}});
            alu_b  = mx_ff - dz_q;
            if (alu_done) begin
               r_in = alu_res[16:0];
               state_in = ST_KMUL;
            end
         end
         ST_KMUL: begin
            alu_a = WIDE_W'(mx_ff);
            alu_b = OPB_W'(r_ff);
            if (alu_done) begin
               k_in = alu_res[FRAC_BITS +: 32];
               state_in = ST_OXM;
            end
         end
         ST_OXM: begin
            alu_a = WIDE_W'(k_ff);
            alu_b = OPB_W'(ax);
            if (alu_done) begin
               p_in = alu_res[WIDE_W-1:0];
               state_in = ST_OXD;
            end
         end
         ST_OXD: begin
            alu_op = ALU_DIV;
            alu_a  = p_ff;
            alu_b  = mag_ff;
            if (alu_done) begin
               ox_in = alu_res[15:0];
               state_in = ST_OYM;
            end
         end
         ST_OYM: begin
            alu_a = WIDE_W'(k_ff);
            alu_b = OPB_W'(ay);
            if (alu_done) begin
               p_in = alu_res[WIDE_W-1:0];
               state_in = ST_OYD;
            end
         end
         ST_OYD: begin
            alu_op = ALU_DIV;
            alu_a  = p_ff;
            alu_b  = mag_ff;
            if (alu_done) begin
               oy_in = alu_res[15:0];
               if ((ox_ff > AXIS_LIMIT) || (alu_res[15:0] > AXIS_LIMIT)) begin
                  state_in = ST_FIX;
               end else begin
                  state_in = ST_TIME;
               end
            end
         end
         ST_FIX: begin
            alu_op = ALU_DIV;
            if (ox_ff > oy_ff) begin
               alu_a = (WIDE_W'(oy_ff) << 15) - WIDE_W'(oy_ff);
               alu_b = OPB_W'(ox_ff);
            end else begin
               alu_a = (WIDE_W'(ox_ff) << 15) - WIDE_W'(ox_ff);
               alu_b = OPB_W'(oy_ff);
            end
            if (alu_done) begin
               if (ox_ff > oy_ff) begin
                  oy_in = alu_res[15:0];
                  ox_in = AXIS_LIMIT;
               end else begin
                  ox_in = alu_res[15:0];
                  oy_in = AXIS_LIMIT;
               end
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            if (unity) begin
               f_in = 20'd1 << FRAC_BITS;
               state_in = ST_TSX;
            end else begin
               state_in = ST_FACT;
            end
         end
         ST_FACT: begin
            alu_op = ALU_DIV;
            alu_a  = WIDE_W'({el_ff, {FRAC_BITS{1'b0}}});
            alu_b  = OPB_W'(cfg.tpf);
            if (alu_done) begin
               f_in = alu_res[19:0];
               state_in = ST_TSX;
            end
         end
         ST_TSX: begin
            alu_a = WIDE_W'(ox_ff);
            alu_b = OPB_W'(f_ff);
            if (alu_done) begin
               tx_in = alu_res[FRAC_BITS +: 19];
               state_in = ST_TSY;
            end
         end
         ST_TSY: begin
            alu_a = WIDE_W'(oy_ff);
            alu_b = OPB_W'(f_ff);
            if (alu_done) begin
               ty_in = alu_res[FRAC_BITS +: 19];
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            alu_op = ALU_DIV;
            alu_a  = WIDE_W'(smx[19:0]);
            alu_b  = OPB_W'(divisor);
            if (alu_done) begin
               qx_in   = sx[23] ? 10'd0 - alu_res[9:0] : alu_res[9:0];
               subx_in = sx[23] ? 24'd0 - 24'(alu_rem[14:0]) : 24'(alu_rem[14:0]);
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            alu_op = ALU_DIV;
            alu_a  = WIDE_W'(smy[19:0]);
            alu_b  = OPB_W'(divisor);
            if (alu_done) begin
               qy_in   = sy[23] ? 10'd0 - alu_res[9:0] : alu_res[9:0];
               suby_in = sy[23] ? 24'd0 - 24'(alu_rem[14:0]) : 24'(alu_rem[14:0]);
               state_in = ST_SQ_RX;
            end
         end
         ST_SQ_RX: begin
            alu_a = WIDE_W'(hx);
            alu_b = OPB_W'(hx);
            if (alu_done) begin
               h2_in = alu_res[31:0];
               state_in = ST_SQ_RY;
            end
         end
         ST_SQ_RY: begin
            alu_a = WIDE_W'(hy);
            alu_b = OPB_W'(hy);
            if (alu_done) begin
               h2_in = h2_ff + alu_res[31:0];
               state_in = ST_SQ_DZ;
            end
         end
         ST_SQ_DZ: begin
            alu_a = WIDE_W'(cfg.dir_dz);
            alu_b = OPB_W'(cfg.dir_dz);
            if (alu_done) begin
               if (h2_ff > alu_res[31:0]) begin
                  state_in = ST_SLX;
               end else begin
                  now_in  = 4'b0000;
                  pend_in = {held_ff, motion};
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SLX: begin
            alu_a = WIDE_W'(SLOPE);
            alu_b = OPB_W'(hx);
            if (alu_done) begin
               sp_in = alu_res[31:0];
               state_in = ST_SLY;
            end
         end
         ST_SLY: begin
            alu_a = WIDE_W'(SLOPE);
            alu_b = OPB_W'(hy);
            if (alu_done) begin
               now_in  = now_c;
               pend_in = {now_c ^ held_ff, motion};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (pend_ff == 5'd0) begin
               held_in  = now_ff;
               state_in = ST_IDLE;
            end else begin
               res_valid = 1'b1;
               res.last  = pend_next == 5'd0;
               if (pend_ff[0]) begin
                  res.event_kind = EVENT_MOTION;
                  res.new_x  = nx;
                  res.new_y  = ny;
                  res.move_x = {1'b0, nx} - {1'b0, px_ff};
                  res.move_y = {1'b0, ny} - {1'b0, py_ff};
               end else begin
                  res.event_kind = EVENT_KEY;
                  res.direction  = dir_sel;
                  res.pressed    = now_ff[dir_sel];
               end
               if (res_ready) begin
                  pend_in = pend_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      go_in = (state_in != state_ff) && !((state_in == ST_IDLE) || (state_in == ST_START)
              || (state_in == ST_TIME) || (state_in == ST_EMIT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         subx_ff  <= '0;
         suby_ff  <= '0;
         fast_ff  <= 1'b0;
         slow_ff  <= 1'b0;
         held_ff  <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         subx_ff  <= subx_in;
         suby_ff  <= suby_in;
         fast_ff  <= fast_in;
         slow_ff  <= slow_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
      lx_ff  <= lx_in;   ly_ff  <= ly_in;   rx_ff <= rx_in;  ry_ff <= ry_in;
      el_ff  <= el_in;   px_ff  <= px_in;   py_ff <= py_in;
      m2_ff  <= m2_in;   mag_ff <= mag_in;  mx_ff <= mx_in;  k_ff  <= k_in;
      r_ff   <= r_in;    p_ff   <= p_in;    ox_ff <= ox_in;  oy_ff <= oy_in;
      f_ff   <= f_in;    tx_ff  <= tx_in;   ty_ff <= ty_in;
      qx_ff  <= qx_in;   qy_ff  <= qy_in;
      now_ff <= now_in;  h2_ff  <= h2_in;   sp_ff <= sp_in;
   end

endmodule

`default_nettype wire

// File: hdl/analog_stick_pointer_and_direction_unit.sv
// A speed item is taken while the engine is idle and leaves it ready; a frame sample runs
// through one shared bit-serial unit for every multiply, divide and root, step by step.
// Throughput: one item at a time; the next sample is taken once all its beats have left.
// Results leave through a one-beat output register, one beat per cycle when drained.
// Reset (synchronous, active high) restores register defaults, clears accumulators,
// speed flags and held directions.
`default_nettype none

`include "analog_stick_pointer_and_direction_unit_macros.svh"

module analog_stick_pointer_and_direction_unit import aspd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [23:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // left_x, left_y, right_x, right_y, elapsed_ticks, pointer_x, pointer_y,
   // fast_request, slow_request, zero fill
   input  wire logic [127:0] req_tdata,
   // kind
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_x, new_y, move_x, move_y, direction, pressed, zero fill
   output logic [55:0]       rsp_tdata,
   // event_kind
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   cfg_type cfg_ff, cfg_in;
   logic    vld_ff, vld_in;
   rsp_type out_ff, out_in;
   req_type item;
   rsp_type res;
   logic    res_valid, res_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_STICK_DZ: cfg_in.stick_dz = csr_wdata[14:0];
            REG_DIR_DZ:   cfg_in.dir_dz   = csr_wdata[15:0];
            REG_TPF:      cfg_in.tpf      = csr_wdata[23:0];
            REG_WIDTH:    cfg_in.width    = csr_wdata[11:0];
            REG_HEIGHT:   cfg_in.height   = csr_wdata[11:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      item.kind          = req_tuser;
      item.left_x        = req_tdata[15:0];
      item.left_y        = req_tdata[31:16];
      item.right_x       = req_tdata[47:32];
      item.right_y       = req_tdata[63:48];
      item.elapsed_ticks = req_tdata[95:64];
      item.pointer_x     = req_tdata[107:96];
      item.pointer_y     = req_tdata[119:108];
      item.fast_request  = req_tdata[120];
      item.slow_request  = req_tdata[121];
   end

   aspd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res        (res),
      .res_ready  (res_ready)
   );

   always_comb begin
      res_ready = !vld_ff || rsp_tready;
      vld_in    = vld_ff;
      out_in    = out_ff;
      if (res_ready) begin
         vld_in = res_valid;
         out_in = res;
      end
      rsp_tvalid = vld_ff;
      rsp_tuser  = out_ff.event_kind;
      rsp_tlast  = out_ff.last;
      rsp_tdata  = {3'b000, out_ff.pressed, out_ff.direction, out_ff.move_y,
                    out_ff.move_x, out_ff.new_y, out_ff.new_x};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_dz <= RST_STICK_DZ;
         cfg_ff.dir_dz   <= RST_DIR_DZ;
         cfg_ff.tpf      <= RST_TPF;
         cfg_ff.width    <= RST_WIDTH;
         cfg_ff.height   <= RST_HEIGHT;
         vld_ff          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         vld_ff <= vld_in;
      end
      out_ff <= out_in;
   end

   `ASPD_ASSERT_NEXT(a_sample_busy, req_tvalid && req_tready && (req_tuser == KIND_SAMPLE), !req_tready, "sample beat taken but engine still ready")
   `ASPD_ASSERT_NEXT(a_speed_idle, req_tvalid && req_tready && (req_tuser == KIND_SPEED), req_tready, "speed beat left engine busy")
   `ASPD_ASSERT_IMPLIES(a_motion_clean, rsp_tvalid && (rsp_tuser == EVENT_MOTION), rsp_tdata[52:50] == 3'b000, "motion beat carries key fields")
   `ASPD_ASSERT_IMPLIES(a_key_clean, rsp_tvalid && (rsp_tuser == EVENT_KEY), rsp_tdata[49:0] == 50'd0, "key beat carries motion fields")

endmodule

`default_nettype wire
